@@ design/bitmap_page_shift_merge_top_assert.svh @@
// Assertion macros used by the checker file of the bitmap page shift merge block.
`ifndef BITMAP_PAGE_SHIFT_MERGE_TOP_ASSERT_SVH
`define BITMAP_PAGE_SHIFT_MERGE_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define BPSM_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bpsm assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define BPSM_IMPLIES_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bpsm assertion failed");

`endif

@@ design/bpsm_pkg.sv @@
// Package: constants, codes and types of the bitmap page shift merge block.
`default_nettype none

package bpsm_pkg;

    // Display geometry
    localparam int SCREEN_COLUMNS = 128;
    localparam int SCREEN_ROWS    = 64;

    // Carry memory address width: one entry per screen column
    localparam int COL_ADDR_W = $clog2(SCREEN_COLUMNS);

    // Configuration port
    localparam int CFG_INDEX_W = 4;

    localparam logic [CFG_INDEX_W-1:0] REG_BITMAP_WIDTH  = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_BITMAP_HEIGHT = CFG_INDEX_W'(1);
    localparam logic [CFG_INDEX_W-1:0] REG_X_POSITION    = CFG_INDEX_W'(2);
    localparam logic [CFG_INDEX_W-1:0] REG_Y_POSITION    = CFG_INDEX_W'(3);

    // Result status codes
    typedef enum logic [1:0] {
        STATUS_PLACED   = 2'd0,
        STATUS_REJECTED = 2'd1,
        STATUS_SURPLUS  = 2'd2
    } status_t;

    // Decoded item handed from the control stage to the merge stage
    typedef struct packed {
        logic [7:0]            data;
        status_t               status;
        logic [COL_ADDR_W-1:0] col_addr;
        logic [7:0]            column;
        logic [2:0]            page;
        logic                  eop;
        logic                  eoi;
        logic [2:0]            shift;
        logic                  use_carry;
        logic                  wr_en;
    } pix_item_t;

    // One result beat
    typedef struct packed {
        logic [7:0] pixel_byte;
        logic [2:0] page_index;
        logic [7:0] column_index;
        logic       end_of_page;
        logic       end_of_image;
        status_t    status;
    } result_t;

endpackage

`default_nettype wire

@@ design/bpsm_in_if.sv @@
// Interface: bitmap byte input channel.
`default_nettype none

interface bpsm_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] bitmap_byte;

    modport source (output valid, output bitmap_byte, input ready);
    modport sink (input valid, input bitmap_byte, output ready);
endinterface

`default_nettype wire

@@ design/bpsm_out_if.sv @@
// Interface: result output channel.
`default_nettype none

interface bpsm_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel_byte;
    logic [2:0] page_index;
    logic [7:0] column_index;
    logic       end_of_page;
    logic       end_of_image;
    logic [1:0] status;

    modport source (output valid, output pixel_byte, output page_index,
                    output column_index, output end_of_page, output end_of_image,
                    output status, input ready);
    modport sink (input valid, input pixel_byte, input page_index,
                  input column_index, input end_of_page, input end_of_image,
                  input status, output ready);
endinterface

`default_nettype wire

@@ design/bpsm_cfg_if.sv @@
// Interface: configuration register write channel.
`default_nettype none

interface bpsm_cfg_if;
    logic       valid;
    logic       ready;
    logic [3:0] reg_index;
    logic [7:0] write_data;

    modport source (output valid, output reg_index, output write_data, input ready);
    modport sink (input valid, input reg_index, input write_data, output ready);
endinterface

`default_nettype wire

@@ design/bpsm_carry_ram.sv @@
// Carry memory: one entry per screen column, one write and one registered read port.
`default_nettype none

module bpsm_carry_ram
    import bpsm_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rd_en,
    input  wire logic [COL_ADDR_W-1:0] rd_addr,
    output logic      [7:0]            rd_data,
    input  wire logic                  wr_en,
    input  wire logic [COL_ADDR_W-1:0] wr_addr,
    input  wire logic [7:0]            wr_data
);

    logic [7:0] mem [SCREEN_COLUMNS];
    logic [7:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, registered
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

@@ design/bpsm_ctrl.sv @@
// Control: configuration registers, column/page counters and per-byte decode.
`default_nettype none

module bpsm_ctrl
    import bpsm_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [7:0]             cfg_data,
    input  wire logic                   accept,
    input  wire logic [7:0]             bitmap_byte,
    output pix_item_t                   item
);

    localparam logic [8:0] COLS_9 = 9'(SCREEN_COLUMNS);
    localparam logic [8:0] ROWS_9 = 9'(SCREEN_ROWS);

    logic [7:0] width_reg, width_next;
    logic [7:0] height_reg, height_next;
    logic [7:0] x_reg, x_next;
    logic [7:0] y_reg, y_next;
    logic [7:0] col_reg, col_next;
    logic [4:0] page_reg, page_next;

    logic       geom_bad;
    logic       surplus;
    logic [4:0] pages;
    logic [2:0] shift;
    logic       eop;
    logic       eoi;
    logic       placed;
    logic       restart;

    // Geometry and progress checks
    always_comb
    begin
        pages    = height_reg[7:3];
        shift    = y_reg[2:0];
        geom_bad = ({1'b0, width_reg} > COLS_9) || ({1'b0, height_reg} > ROWS_9) ||
                   ({1'b0, x_reg} >= COLS_9) || ({1'b0, y_reg} >= ROWS_9);
        surplus  = (width_reg == 8'd0) || (page_reg >= pages) || ({1'b0, col_reg} >= COLS_9);
        eop      = (({1'b0, col_reg} + 9'd1) == {1'b0, width_reg});
        eoi      = eop && (({1'b0, page_reg} + 6'd1) == {1'b0, pages});
        placed   = !geom_bad && !surplus;
    end

    // Decoded item; all fields but the status zero unless placed
    always_comb
    begin
        item = '0;
        if (geom_bad)
        begin
            item.status = STATUS_REJECTED;
        end
        else if (surplus)
        begin
            item.status = STATUS_SURPLUS;
        end
        else
        begin
            item.status    = STATUS_PLACED;
            item.data      = bitmap_byte;
            item.col_addr  = col_reg[COL_ADDR_W-1:0];
            item.column    = x_reg + col_reg;
            item.page      = y_reg[5:3] + page_reg[2:0];
            item.eop       = eop;
            item.eoi       = eoi;
            item.shift     = shift;
            item.use_carry = (shift != 3'd0) && (page_reg != 5'd0);
            item.wr_en     = (shift != 3'd0);
        end
    end

    // Register writes and counter update
    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        col_next    = col_reg;
        page_next   = page_reg;
        restart     = 1'b0;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_BITMAP_WIDTH:
                begin
                    width_next = cfg_data;
                    restart    = 1'b1;
                end
                REG_BITMAP_HEIGHT:
                begin
                    height_next = cfg_data;
                    restart     = 1'b1;
                end
                REG_X_POSITION:
                begin
                    x_next  = cfg_data;
                    restart = 1'b1;
                end
                REG_Y_POSITION:
                begin
                    y_next  = cfg_data;
                    restart = 1'b1;
                end
                default:
                begin
                    restart = 1'b0;
                end
            endcase
        end
        if (restart)
        begin
            col_next  = 8'd0;
            page_next = 5'd0;
        end
        else if (accept && placed)
        begin
            if (eop)
            begin
                col_next  = 8'd0;
                page_next = page_reg + 5'd1;
            end
            else
            begin
                col_next = col_reg + 8'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 8'd0;
            height_reg <= 8'd0;
            x_reg      <= 8'd0;
            y_reg      <= 8'd0;
            col_reg    <= 8'd0;
            page_reg   <= 5'd0;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            x_reg      <= x_next;
            y_reg      <= y_next;
            col_reg    <= col_next;
            page_reg   <= page_next;
        end
    end

endmodule

`default_nettype wire

@@ design/bpsm_merge.sv @@
// Merge stage: carry read-modify-write around the carry memory, then the output register.
`default_nettype none

module bpsm_merge
    import bpsm_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  pix_item_t      item,
    output logic           out_valid,
    input  wire logic      out_ready,
    output result_t        result
);

    logic       s1_valid_reg, s1_valid_next;
    pix_item_t  s1_item_reg;
    logic       fwd_valid_reg;
    logic [7:0] fwd_data_reg;
    logic       out_valid_reg, out_valid_next;
    result_t    out_reg;

    logic        out_take;
    logic        s1_adv;
    logic        accept;
    logic [15:0] wide;
    logic [7:0]  carry_in;
    logic [7:0]  rd_data;
    logic        wr_en;
    result_t     s1_result;

    // Handshake: s1 moves when the output register is free or being drained
    always_comb
    begin
        out_take = !out_valid_reg || out_ready;
        s1_adv   = s1_valid_reg && out_take;
        in_ready = !s1_valid_reg || out_take;
        accept   = in_valid && in_ready;
    end

    // Shift and merge with the carry from the page above
    always_comb
    begin
        wide     = 16'(s1_item_reg.data) << s1_item_reg.shift;
        carry_in = 8'd0;
        if (s1_item_reg.use_carry)
        begin
            carry_in = fwd_valid_reg ? fwd_data_reg : rd_data;
        end
        wr_en                  = s1_adv && s1_item_reg.wr_en;
        s1_result.pixel_byte   = wide[7:0] | carry_in;
        s1_result.page_index   = s1_item_reg.page;
        s1_result.column_index = s1_item_reg.column;
        s1_result.end_of_page  = s1_item_reg.eop;
        s1_result.end_of_image = s1_item_reg.eoi;
        s1_result.status       = s1_item_reg.status;
    end

    bpsm_carry_ram u_carry_ram (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (item.col_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (s1_item_reg.col_addr),
        .wr_data (wide[15:8])
    );

    // Valid flags
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (out_take)
        begin
            out_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            // Bypass a carry written at the same edge the next read is issued
            if (accept)
            begin
                fwd_valid_reg <= wr_en && (s1_item_reg.col_addr == item.col_addr);
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg  <= item;
            fwd_data_reg <= wide[15:8];
        end
        if (s1_adv)
        begin
            out_reg <= s1_result;
        end
    end

    assign out_valid = out_valid_reg;
    assign result    = out_reg;

endmodule

`default_nettype wire

@@ design/bitmap_page_shift_merge_top.sv @@
// Top level of the bitmap page shift merge block.
// Accepts one bitmap byte per clock unless the output stalls, and returns one result
// beat per byte, in order, via the merge stage and output registers. The rate is set
// by the carry memory, which serves one read (at accept) and one write (at the merge
// stage) per cycle; a carry written and read for the same column in the same cycle is
// bypassed. Configuration writes are taken every cycle; known registers restart the
// image; carry memory needs no clearing after reset: the first page never reads it.
`default_nettype none

module bitmap_page_shift_merge_top
    import bpsm_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    bpsm_cfg_if.sink   cfg,
    bpsm_in_if.sink    bitmap,
    bpsm_out_if.source result
);

    pix_item_t item;
    result_t   res;
    logic      in_ready;
    logic      accept;

    assign cfg.ready    = 1'b1;
    assign bitmap.ready = in_ready;
    assign accept       = bitmap.valid && in_ready;

    bpsm_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg.valid),
        .cfg_index   (cfg.reg_index),
        .cfg_data    (cfg.write_data),
        .accept      (accept),
        .bitmap_byte (bitmap.bitmap_byte),
        .item        (item)
    );

    bpsm_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (bitmap.valid),
        .in_ready  (in_ready),
        .item      (item),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .result    (res)
    );

    // Result beat fields
    assign result.pixel_byte   = res.pixel_byte;
    assign result.page_index   = res.page_index;
    assign result.column_index = res.column_index;
    assign result.end_of_page  = res.end_of_page;
    assign result.end_of_image = res.end_of_image;
    assign result.status       = res.status;

endmodule

`default_nettype wire

@@ design/bpsm_checker.sv @@
// Port-level checker for the bitmap page shift merge block, bound to the top level.
`default_nettype none

`include "bitmap_page_shift_merge_top_assert.svh"

module bpsm_checker
    import bpsm_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [7:0] pixel_byte,
    input wire logic [2:0] page_index,
    input wire logic [7:0] column_index,
    input wire logic       end_of_page,
    input wire logic       end_of_image,
    input wire logic [1:0] status
);

    logic not_placed;
    logic known_status;
    logic fields_zero;

    assign not_placed   = (status == STATUS_REJECTED) || (status == STATUS_SURPLUS);
    assign known_status = (status == STATUS_PLACED) || not_placed;
    assign fields_zero  = (pixel_byte == 8'd0) && (page_index == 3'd0) &&
                          (column_index == 8'd0) && !end_of_page && !end_of_image;

    // Rejected and surplus beats carry no placement
    `BPSM_IMPLIES(a_unplaced_zero, out_valid && not_placed, fields_zero)
    // Last byte of the image is always the last column of a page
    `BPSM_IMPLIES(a_eoi_has_eop, out_valid && end_of_image, end_of_page && (status == STATUS_PLACED))
    // Status is always one of the defined codes
    `BPSM_IMPLIES(a_status_code, out_valid, known_status)
    // A stalled beat holds
    `BPSM_IMPLIES_NEXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(pixel_byte) && $stable(column_index))

endmodule

bind bitmap_page_shift_merge_top bpsm_checker u_bpsm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (result.valid),
    .out_ready    (result.ready),
    .pixel_byte   (result.pixel_byte),
    .page_index   (result.page_index),
    .column_index (result.column_index),
    .end_of_page  (result.end_of_page),
    .end_of_image (result.end_of_image),
    .status       (result.status)
);

`default_nettype wire

@@ test/bitmap_page_shift_merge_top_tb.sv @@
// Testbench for the bitmap page shift merge block: random geometry and bytes, scoreboard check.
`timescale 1ns / 1ps

module bitmap_page_shift_merge_top_tb;
    import bpsm_pkg::*;

    localparam int PLACED_TARGET = 1450;
    localparam int LONG_HOLD_CYCLES = 150;

    logic clk;
    logic rst_n;

    bpsm_cfg_if cfg_ch();
    bpsm_in_if  in_ch();
    bpsm_out_if out_ch();

    bitmap_page_shift_merge_top u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_ch),
        .bitmap (in_ch),
        .result (out_ch)
    );

    // Predicted block state: geometry registers, carry memory, position counters
    logic [7:0] geo_width  = '0;
    logic [7:0] geo_height = '0;
    logic [7:0] geo_x      = '0;
    logic [7:0] geo_y      = '0;
    logic [7:0] carry_mem [SCREEN_COLUMNS];
    logic [7:0] col_count  = '0;
    logic [4:0] page_count = '0;

    // Bytes waiting to be sent, results waiting to come back
    logic [7:0] pending_bytes [$];
    result_t    expected_pixels [$];

    // Driver and receiver state
    logic        in_beat_taken = 1'b0;
    int unsigned burst_left = 0;
    int unsigned gap_left = 0;
    int unsigned stall_left = 0;
    logic        long_hold_done = 1'b0;
    int unsigned rx_mode = 0;
    int unsigned rx_mode_left = 0;
    int unsigned rx_tick = 0;

    // Run statistics
    int unsigned mismatches = 0;
    int unsigned placed_seen = 0;
    int unsigned rejected_seen = 0;
    int unsigned surplus_seen = 0;
    int unsigned reg_writes = 0;
    int unsigned images = 0;

    initial
    begin
        for (int i = 0; i < SCREEN_COLUMNS; i++)
        begin
            carry_mem[i] = '0;
        end
    end

    // Shift one bitmap byte into place, merging the carry from the page above
    function automatic result_t blit_byte(input logic [7:0] b);
        result_t     r;
        int unsigned pages;
        logic [2:0]  shift;
        logic [7:0]  carry_in;
        logic        last_col;
        r = '0;
        pages = geo_height / 8;
        shift = geo_y[2:0];
        carry_in = '0;
        if (geo_width > SCREEN_COLUMNS || geo_height > SCREEN_ROWS ||
            geo_x >= SCREEN_COLUMNS || geo_y >= SCREEN_ROWS)
        begin
            r.status = STATUS_REJECTED;
            return r;
        end
        if (geo_width == 0 || page_count >= pages || col_count >= SCREEN_COLUMNS)
        begin
            r.status = STATUS_SURPLUS;
            return r;
        end
        if (shift == 0)
        begin
            r.pixel_byte = b;
        end
        else
        begin
            if (page_count != 0)
            begin
                carry_in = carry_mem[col_count];
            end
            carry_mem[col_count] = b >> (8 - shift);
            r.pixel_byte = (b << shift) | carry_in;
        end
        r.page_index   = geo_y[5:3] + page_count[2:0];
        r.column_index = geo_x + col_count;
        last_col = (int'(col_count) + 1 == int'(geo_width));
        r.end_of_page  = last_col;
        r.end_of_image = last_col && (int'(page_count) + 1 == pages);
        r.status       = STATUS_PLACED;
        if (last_col)
        begin
            col_count  = '0;
            page_count = page_count + 5'd1;
        end
        else
        begin
            col_count = col_count + 8'd1;
        end
        return r;
    endfunction

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Scoreboard: register writes, accepted bytes, returned pixels
    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        logic    cfg_hit;
        if (rst_n)
        begin
            in_beat_taken <= in_ch.valid && in_ch.ready;
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                reg_writes++;
                cfg_hit = 1'b1;
                case (cfg_ch.reg_index)
                    REG_BITMAP_WIDTH:  geo_width  = cfg_ch.write_data;
                    REG_BITMAP_HEIGHT: geo_height = cfg_ch.write_data;
                    REG_X_POSITION:    geo_x      = cfg_ch.write_data;
                    REG_Y_POSITION:    geo_y      = cfg_ch.write_data;
                    default:           cfg_hit    = 1'b0;
                endcase
                // Only a known register restarts the image
                if (cfg_hit)
                begin
                    col_count  = '0;
                    page_count = '0;
                end
            end
            if (in_ch.valid && in_ch.ready)
            begin
                expected_pixels.push_back(blit_byte(in_ch.bitmap_byte));
            end
            if (out_ch.valid && out_ch.ready)
            begin
                got.pixel_byte   = out_ch.pixel_byte;
                got.page_index   = out_ch.page_index;
                got.column_index = out_ch.column_index;
                got.end_of_page  = out_ch.end_of_page;
                got.end_of_image = out_ch.end_of_image;
                got.status       = status_t'(out_ch.status);
                if (expected_pixels.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("%0t: unexpected beat: byte %02h page %0d col %0d status %0d",
                                 $realtime, got.pixel_byte, got.page_index,
                                 got.column_index, got.status);
                    end
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    case (want.status)
                        STATUS_PLACED:   placed_seen++;
                        STATUS_REJECTED: rejected_seen++;
                        default:         surplus_seen++;
                    endcase
                    if (got.pixel_byte !== want.pixel_byte ||
                        got.page_index !== want.page_index ||
                        got.column_index !== want.column_index ||
                        got.end_of_page !== want.end_of_page ||
                        got.end_of_image !== want.end_of_image ||
                        got.status !== want.status)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("%0t: exp byte %02h pg %0d col %0d eop %0b eoi %0b st %0d",
                                     $realtime, want.pixel_byte, want.page_index,
                                     want.column_index, want.end_of_page,
                                     want.end_of_image, want.status);
                            $display("%0t: got byte %02h pg %0d col %0d eop %0b eoi %0b st %0d",
                                     $realtime, got.pixel_byte, got.page_index,
                                     got.column_index, got.end_of_page,
                                     got.end_of_image, got.status);
                        end
                    end
                end
            end
        end
    end

    // Byte driver: bursts of random length separated by random gaps
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
        end
        else if (!in_ch.valid || in_beat_taken)
        begin
            if (gap_left != 0)
            begin
                gap_left <= gap_left - 1;
                in_ch.valid <= 1'b0;
            end
            else if (pending_bytes.size() != 0)
            begin
                in_ch.valid <= 1'b1;
                in_ch.bitmap_byte <= pending_bytes.pop_front();
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 40);
                    case ($urandom_range(0, 9))
                        0, 1, 2: gap_left <= 0;
                        3:       gap_left <= $urandom_range(20, 40);
                        default: gap_left <= $urandom_range(1, 8);
                    endcase
                end
                else
                begin
                    burst_left <= burst_left - 1;
                end
            end
            else
            begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // Result receiver: stall pattern switches mode after each random-length run;
    // one long hold-off while the byte queue is deep
    always @(negedge clk)
    begin
        rx_tick <= rx_tick + 1;
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
        end
        else if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            out_ch.ready <= 1'b0;
        end
        else if (!long_hold_done && pending_bytes.size() > 40)
        begin
            stall_left <= LONG_HOLD_CYCLES;
            long_hold_done <= 1'b1;
            out_ch.ready <= 1'b0;
        end
        else
        begin
            if (rx_mode_left == 0)
            begin
                rx_mode <= $urandom_range(0, 3);
                rx_mode_left <= $urandom_range(20, 200);
            end
            else
            begin
                rx_mode_left <= rx_mode_left - 1;
            end
            case (rx_mode)
                0:       out_ch.ready <= 1'b1;
                1:       out_ch.ready <= $urandom_range(0, 1);
                2:       out_ch.ready <= (rx_tick % 3 == 0);
                default: out_ch.ready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    // Wait until every byte is sent and every pixel has come back
    task automatic wait_idle();
        @(posedge clk);
        while (pending_bytes.size() != 0 || in_ch.valid || expected_pixels.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] val);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.reg_index <= idx;
        cfg_ch.write_data <= val;
        @(posedge clk);
        while (!cfg_ch.ready)
        begin
            @(posedge clk);
        end
    endtask

    // Set up a new placement once the block has drained; mask picks registers
    task automatic place_image(input logic [7:0] w, input logic [7:0] h,
                               input logic [7:0] x, input logic [7:0] y,
                               input logic [3:0] mask);
        wait_idle();
        images++;
        if (mask[0]) write_reg(REG_BITMAP_WIDTH, w);
        if (mask[1]) write_reg(REG_BITMAP_HEIGHT, h);
        if (mask[2]) write_reg(REG_X_POSITION, x);
        if (mask[3]) write_reg(REG_Y_POSITION, y);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic queue_random_bytes(input int unsigned n);
        for (int unsigned i = 0; i < n; i++)
        begin
            pending_bytes.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    // Stimulus
    initial
    begin
        int unsigned placed_goal;
        int unsigned kind;
        int unsigned full;
        int unsigned n;
        int unsigned img_no;
        logic [7:0]  w, h, x, y;
        logic [3:0]  mask;

        placed_goal = 0;
        img_no = 0;
        rst_n = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.reg_index = '0;
        cfg_ch.write_data = '0;
        in_ch.valid = 1'b0;
        in_ch.bitmap_byte = '0;
        out_ch.ready = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset geometry has zero width: surplus
        pending_bytes.push_back(8'hFF);

        // Full shift of seven with carry into the second page, then one surplus byte
        place_image(8'd2, 8'd16, 8'd126, 8'd7, 4'hF);
        pending_bytes.push_back(8'hFF);
        pending_bytes.push_back(8'h80);
        pending_bytes.push_back(8'h01);
        pending_bytes.push_back(8'hFF);
        pending_bytes.push_back(8'h5A);

        // No shift, start on the last page so the page index wraps, tallest image
        place_image(8'd1, 8'd64, 8'd127, 8'd56, 4'hF);
        pending_bytes.push_back(8'h00);
        pending_bytes.push_back(8'hFF);
        pending_bytes.push_back(8'h55);
        pending_bytes.push_back(8'hAA);
        pending_bytes.push_back(8'h01);
        pending_bytes.push_back(8'h80);
        pending_bytes.push_back(8'h7E);
        pending_bytes.push_back(8'h3C);

        // Rejected geometry, one limit at a time, then everything at its maximum
        place_image(8'd129, 8'd8, 8'd0, 8'd0, 4'hF);
        pending_bytes.push_back(8'hC3);
        place_image(8'd1, 8'd65, 8'd0, 8'd0, 4'h3);
        pending_bytes.push_back(8'h3C);
        place_image(8'd1, 8'd8, 8'd128, 8'd0, 4'h6);
        pending_bytes.push_back(8'h0F);
        place_image(8'd1, 8'd8, 8'd0, 8'd64, 4'hC);
        pending_bytes.push_back(8'hF0);
        place_image(8'd255, 8'd255, 8'd255, 8'd255, 4'hF);
        pending_bytes.push_back(8'h99);

        // Height below one page: every byte is surplus
        place_image(8'd3, 8'd7, 8'd0, 8'd3, 4'hF);
        pending_bytes.push_back(8'h66);

        // Random images
        while (placed_goal < PLACED_TARGET)
        begin
            img_no++;
            kind = $urandom_range(0, 99);
            mask = 4'hF;
            w = 8'($urandom_range(1, 12));
            h = 8'($urandom_range(8, 64));
            x = 8'($urandom_range(0, 127));
            y = 8'($urandom_range(0, 63));
            if (img_no == 1)
            begin
                // deep enough to back the block up during the long hold-off
                w = 8'd64;
                h = 8'd16;
            end
            else if (img_no == 2)
            begin
                w = 8'd128;
                h = 8'd8;
                x = 8'd0;
            end
            else if (img_no % 16 == 5)
            begin
                w = 8'($urandom_range(100, 128));
                h = 8'($urandom_range(8, 15));
            end
            if (img_no <= 2 || kind < 75)
            begin
                // Well-formed image, sometimes cut short, sometimes only the
                // vertical placement rewritten
                if (img_no > 2 && $urandom_range(0, 4) == 0)
                begin
                    mask = 4'h8;
                    w = geo_width;
                    h = geo_height;
                    x = geo_x;
                    if (w == 0 || w > SCREEN_COLUMNS || h > SCREEN_ROWS || x >= SCREEN_COLUMNS)
                    begin
                        mask = 4'hF;
                        w = 8'($urandom_range(1, 12));
                        h = 8'($urandom_range(8, 64));
                        x = 8'($urandom_range(0, 127));
                    end
                end
                full = int'(w) * (int'(h) / 8);
                n = full + $urandom_range(0, 2);
                if (img_no > 2 && $urandom_range(0, 9) == 0)
                begin
                    n = $urandom_range(1, full);
                end
                placed_goal += (n < full) ? n : full;
            end
            else if (kind < 90)
            begin
                // Arbitrary register values, mostly rejected
                w = 8'($urandom_range(0, 255));
                h = 8'($urandom_range(0, 255));
                x = 8'($urandom_range(0, 255));
                y = 8'($urandom_range(0, 255));
                n = $urandom_range(1, 4);
            end
            else
            begin
                // Empty image: no columns or less than one page
                if ($urandom_range(0, 1) == 0)
                begin
                    w = 8'd0;
                end
                else
                begin
                    h = 8'($urandom_range(0, 7));
                end
                n = $urandom_range(1, 3);
            end
            place_image(w, h, x, y, mask);
            queue_random_bytes(n);
        end

        wait_idle();
        repeat (10) @(posedge clk);
        $display("Ran %0d placements over %0d register writes; long output hold-off %0s.",
                 images, reg_writes, long_hold_done ? "applied" : "missed");
        $display("Checked %0d placed, %0d rejected and %0d surplus beats; %0d mismatches.",
                 placed_seen, rejected_seen, surplus_seen, mismatches);
        if (mismatches == 0 && expected_pixels.size() == 0)
        begin
            $display("bitmap_page_shift_merge_top_tb OK");
        end
        else
        begin
            $display("bitmap_page_shift_merge_top_tb NOT OK");
        end
        $finish;
    end

    // Watchdog
    initial
    begin
        #5_000_000;
        $display("bitmap_page_shift_merge_top_tb NOT OK");
        $finish;
    end

endmodule

@@ bitmap_page_shift_merge_top.f @@
+incdir+design
design/bpsm_pkg.sv
design/bpsm_in_if.sv
design/bpsm_out_if.sv
design/bpsm_cfg_if.sv
design/bpsm_carry_ram.sv
design/bpsm_ctrl.sv
design/bpsm_merge.sv
design/bitmap_page_shift_merge_top.sv
design/bpsm_checker.sv
test/bitmap_page_shift_merge_top_tb.sv
